[hw/rtl/rsm_pkg.sv]
// Shared types and constants for the release-sort makespan block.
// No dependencies; compile first.
package rsm_pkg;

    localparam int DATA_W = 16;
    localparam int TIME_W = 21;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [TIME_W-1:0] t_time;

    // One stored job: release, processing and delivery times.
    typedef struct packed {
        t_data r;
        t_data p;
        t_data q;
    } t_job;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic ins;
        logic pop;
        t_job job;
    } t_cell_ctl;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic valid;
        logic gt;
        t_job job;
    } t_cell_link;

endpackage

[hw/rtl/rsm_if.sv]
// Valid/ready channel interfaces for jobs in and scheduled results out.
// Depends on rsm_pkg.
interface rsm_job_if;
    logic               valid;
    logic               ready;
    rsm_pkg::t_data     release_time;
    rsm_pkg::t_data     proc_time;
    rsm_pkg::t_data     delivery_time;
    logic               last_job;

    modport source (output valid, release_time, proc_time, delivery_time, last_job,
                    input ready);
    modport sink (input valid, release_time, proc_time, delivery_time, last_job,
                  output ready);
endinterface

interface rsm_res_if;
    logic               valid;
    logic               ready;
    rsm_pkg::t_data     out_release;
    rsm_pkg::t_data     out_proc;
    rsm_pkg::t_data     out_delivery;
    rsm_pkg::t_time     finish_time;
    rsm_pkg::t_time     makespan;
    logic               overflow;
    logic               last_result;

    modport source (output valid, out_release, out_proc, out_delivery, finish_time,
                    makespan, overflow, last_result, input ready);
    modport sink (input valid, out_release, out_proc, out_delivery, finish_time,
                  makespan, overflow, last_result, output ready);
endinterface

[hw/rtl/release_sort_makespan_core.sv]
// Release-sort makespan core: insertion chain of MAX_JOBS cells plus scheduler.
// Throughput: one job per cycle while loading; after the last job, one result per cycle
// while the output is ready. The last job moves the sequencer to the emit state; each pop
// then shifts the chain one cell down into the scheduler, which registers the result.
// Reset (synchronous, active low) empties the chain and clears time and drop state.
// Depends on rsm_pkg, rsm_if, rsm_cell and rsm_sched.
module release_sort_makespan_core #(
    parameter int MAX_JOBS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsm_job_if.sink   i_job,
    rsm_res_if.source o_res
);
    import rsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_dropped;

    logic               w_accept;
    logic               w_full;
    logic               w_take;
    logic               w_pop;
    logic               w_last;
    t_cell_ctl          w_ctl;
    t_cell_link         w_lnk [0:MAX_JOBS];

    // Take jobs only while collecting; the emit phase owns the chain.
    assign i_job.ready = (r_state == ST_COLLECT);
    assign w_accept    = i_job.valid && i_job.ready;
    assign w_full      = (r_count == CNT_W'(MAX_JOBS));
    assign w_pop       = (r_state == ST_EMIT) && w_take;
    assign w_last      = (r_count == CNT_W'(1));

    assign w_ctl.ins   = w_accept && !w_full;
    assign w_ctl.pop   = w_pop;
    assign w_ctl.job   = '{r: i_job.release_time, p: i_job.proc_time,
                           q: i_job.delivery_time};

    // Left edge of the chain: never "later", so cell 0 takes the new job when it shifts.
    assign w_lnk[0] = '{valid: 1'b0, gt: 1'b0, job: '0};

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        t_cell_link w_right;
        if (g < MAX_JOBS - 1) begin : g_mid
            assign w_right = w_lnk[g + 2];
        end else begin : g_end
            assign w_right = '{valid: 1'b0, gt: 1'b1, job: '0};
        end
        rsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_lnk[g]),
            .i_right (w_right),
            .o_link  (w_lnk[g + 1])
        );
    end

    // Head cell feeds the scheduler; the chain shifts down on every pop.
    rsm_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pop   (w_pop),
        .i_job   (w_lnk[1].job),
        .i_last  (w_last),
        .i_ovf   (r_dropped),
        .o_take  (w_take),
        .o_res   (o_res)
    );

    // Sequencer: count stored jobs, flag drops, switch to emit on the last job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            unique case (r_state)
                ST_COLLECT: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_job.last_job) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_pop) begin
                        r_count <= r_count - CNT_W'(1);
                        if (w_last) begin
                            r_state   <= ST_COLLECT;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    // The stored count never exceeds the chain length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count beyond chain length");

    // While emitting, the head cell always holds a job.
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_lnk[1].valid)
        else $error("emit with empty head cell");

    // Popping the final job ends the set with an empty chain.
    a_set_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_last) |=> (r_state == ST_COLLECT) && !w_lnk[1].valid)
        else $error("chain not empty after final result");

    // A result marked last leaves the scheduler only from the final pop.
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_res.last_result == $past(w_last)))
        else $error("last_result mark mismatch");

endmodule

[hw/rtl/rsm_cell.sv]
// One cell of the sorted job chain: holds a job, inserts or shifts.
// Depends on rsm_pkg.
module rsm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsm_pkg::t_cell_ctl  i_ctl,
    input  rsm_pkg::t_cell_link i_left,
    input  rsm_pkg::t_cell_link i_right,
    output rsm_pkg::t_cell_link o_link
);
    import rsm_pkg::*;

    logic r_vld;
    t_job r_job;
    logic w_gt;

    // Empty cells count as later than any job; equal release stays ahead (stable).
    assign w_gt = !r_vld || (r_job.r > i_ctl.job.r);

    assign o_link = '{valid: r_vld, gt: w_gt, job: r_job};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.pop) begin
            r_vld <= i_right.valid;
        end else if (i_ctl.ins && w_gt) begin
            r_vld <= i_left.gt ? i_left.valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_job <= i_right.job;
        end else if (i_ctl.ins && w_gt) begin
            r_job <= i_left.gt ? i_left.job : i_ctl.job;
        end
    end

endmodule

[hw/rtl/rsm_sched.sv]
// Single-machine scheduler at the head of the chain, with the result register.
// Depends on rsm_pkg and rsm_if.
module rsm_sched (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  rsm_pkg::t_job i_job,
    input  logic          i_last,
    input  logic          i_ovf,
    output logic          o_take,
    rsm_res_if.source     o_res
);
    import rsm_pkg::*;

    logic              r_vld;
    t_time             r_run;
    t_time             r_span;
    t_job              r_job;
    t_time             r_fin;
    t_time             r_ms;
    logic              r_ovf;
    logic              r_last;
    t_time             w_start;
    logic [TIME_W:0]   w_sum_fin;
    logic [TIME_W:0]   w_sum_span;
    t_time             w_fin;
    t_time             w_span;
    t_time             w_ms;

    assign o_take = !r_vld || o_res.ready;

    always_comb begin
        w_start    = (TIME_W'(i_job.r) > r_run) ? TIME_W'(i_job.r) : r_run;
        w_sum_fin  = {1'b0, w_start} + (TIME_W + 1)'(i_job.p);
        w_fin      = w_sum_fin[TIME_W] ? TIME_MAX : w_sum_fin[TIME_W-1:0];
        w_sum_span = {1'b0, w_fin} + (TIME_W + 1)'(i_job.q);
        w_span     = w_sum_span[TIME_W] ? TIME_MAX : w_sum_span[TIME_W-1:0];
        w_ms       = (w_span > r_span) ? w_span : r_span;
    end

    // Machine time and makespan restart after the final job of a set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_run  <= '0;
            r_span <= '0;
        end else begin
            if (i_pop) begin
                r_vld  <= 1'b1;
                r_run  <= i_last ? '0 : w_fin;
                r_span <= i_last ? '0 : w_ms;
            end else if (o_res.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_job  <= i_job;
            r_fin  <= w_fin;
            r_ms   <= w_ms;
            r_ovf  <= i_ovf;
            r_last <= i_last;
        end
    end

    assign o_res.valid        = r_vld;
    assign o_res.out_release  = r_job.r;
    assign o_res.out_proc     = r_job.p;
    assign o_res.out_delivery = r_job.q;
    assign o_res.finish_time  = r_fin;
    assign o_res.makespan     = r_ms;
    assign o_res.overflow     = r_ovf;
    assign o_res.last_result  = r_last;

endmodule
